// ===== hw/rtl/ntc_pkg.sv =====
`timescale 1ns / 1ps

package ntc_pkg;

    // ln(2) in Q16
    localparam int unsigned LN2_Q16 = 45426;

    // Width of a resistance that can pass the limit test (at most 1000000 ohms).
    localparam int unsigned RES_W = 20;
    // Width of ln(x) in Q16 for a RES_W-bit x.
    localparam int unsigned LN_W = 20;
    // Width of ln(R) - ln(R0).
    localparam int unsigned LDIFF_W = LN_W + 1;

    localparam int unsigned RES_MIN = 50;
    localparam int unsigned RES_MAX = 1000000;
    localparam int unsigned RES_SAT = 16777215;
    localparam int unsigned KELVIN_OFS = 27315;
    localparam int unsigned TK_SAT = 127315;
    localparam int unsigned VOLT_MARGIN = 1000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DISC   = 2'd1,
        ST_UNREAL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_SERIES     = 3'd0,
        CFG_NOMINAL_R  = 3'd1,
        CFG_NOMINAL_T  = 3'd2,
        CFG_BETA       = 3'd3,
        CFG_DIV_REF    = 3'd4,
        CFG_ADC_REF    = 3'd5,
        CFG_FULL_SCALE = 3'd6
    } t_cfg_idx;

    // Shift-subtract division, used only while the log table is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], a[k]};
            if (r >= {1'b0, b}) begin
                r = r - {1'b0, b};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/n) in Q16, rounded to nearest, by the series
    // 2 atanh(i / (2n + i)) summed in Q32.
    function automatic logic [15:0] ln_entry(input int unsigned i, input int unsigned n);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] full;
        z = udiv64(64'(i) << 32, 64'(2 * n + i));
        z2 = (z * z) >> 32;
        term = z;
        sum = '0;
        k = 64'd1;
        while (term != 64'd0 && k < 64'd200) begin
            sum = sum + udiv64(term, k);
            term = (term * z2) >> 32;
            k = k + 64'd2;
        end
        full = (64'd2 * sum + 64'd32768) >> 16;
        return full[15:0];
    endfunction

endpackage

// ===== hw/rtl/ntc_div.sv =====
`timescale 1ns / 1ps

module ntc_div #(
    parameter int DW = 38,
    parameter int VW = 15,
    parameter int QW = 23,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [PW-1:0] i_payload,
    output logic          o_valid,
    output logic [QW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder,
    output logic [PW-1:0] o_payload
);
    // Restoring divider, one quotient bit per stage. The caller guarantees
    // dividend >> QW < divisor, or ignores the quotient.

    logic          r_v   [0:QW-1];
    logic [VW-1:0] r_rem [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [QW-1:0] r_q   [0:QW-1];
    logic [VW-1:0] r_d   [0:QW-1];
    logic [PW-1:0] r_p   [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic          v_in;
        logic [VW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [VW-1:0] d_in;
        logic [PW-1:0] p_in;
        logic [VW:0]   t;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = VW'(i_dividend >> QW);
            assign low_in = i_dividend[QW-1:0];
            assign q_in   = '0;
            assign d_in   = i_divisor;
            assign p_in   = i_payload;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
            assign p_in   = r_p[k-1];
        end

        assign t  = {rem_in, low_in[QW-1]};
        assign ge = (t >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? VW'(t - {1'b0, d_in}) : t[VW-1:0];
                r_low[k] <= low_in << 1;
                r_q[k]   <= (q_in << 1) | QW'(ge);
                r_d[k]   <= d_in;
                r_p[k]   <= p_in;
            end
        end
    end

    assign o_valid     = r_v[QW-1];
    assign o_quotient  = r_q[QW-1];
    assign o_remainder = r_rem[QW-1];
    assign o_payload   = r_p[QW-1];

endmodule

// ===== hw/rtl/ntc_ln.sv =====
`timescale 1ns / 1ps

module ntc_ln #(
    parameter int TAB_N = 256,
    parameter int PW    = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [ntc_pkg::RES_W-1:0]           i_x0,
    input  logic [ntc_pkg::RES_W-1:0]           i_x1,
    input  logic [PW-1:0]                       i_payload,
    output logic                                o_valid,
    output logic signed [ntc_pkg::LDIFF_W-1:0]  o_diff,
    output logic [PW-1:0]                       o_payload
);
    import ntc_pkg::*;

    // ln(x0) - ln(x1) in Q16. Each lane: leading one, mantissa fraction,
    // table index, table read, interpolation; then the difference.
    localparam int XW  = RES_W;
    localparam int EW  = $clog2(XW);
    localparam int IW  = $clog2(TAB_N + 1);
    localparam int PSW = 32 + IW;
    localparam int LAT = 6;

    logic [15:0] w_tab [0:TAB_N];

    for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
        localparam logic [15:0] Entry = ln_entry(g, TAB_N);
        assign w_tab[g] = Entry;
    end

    logic [XW-1:0]   w_x    [0:1];
    logic [XW-1:0]   r_x1   [0:1];
    logic [EW-1:0]   r_e1   [0:1];
    logic [31:0]     r_frac [0:1];
    logic [EW-1:0]   r_e2   [0:1];
    logic [IW-1:0]   r_idx  [0:1];
    logic [31:0]     r_rem3 [0:1];
    logic [EW-1:0]   r_e3   [0:1];
    logic [15:0]     r_a    [0:1];
    logic [15:0]     r_dif  [0:1];
    logic [31:0]     r_rem4 [0:1];
    logic [EW-1:0]   r_e4   [0:1];
    logic [LN_W-1:0] r_ln   [0:1];

    logic                      r_vv [0:LAT-1];
    logic [PW-1:0]             r_pp [0:LAT-1];
    logic signed [LDIFF_W-1:0] r_diff;

    assign w_x[0] = i_x0;
    assign w_x[1] = i_x1;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [XW-1:0]   xn;
        logic [EW-1:0]   msb;
        logic [XW-1:0]   rest;
        logic [31:0]     frac;
        logic [PSW-1:0]  pos;
        logic [15:0]     ta;
        logic [15:0]     tb;
        logic [15:0]     tbb;
        logic [47:0]     prod;
        logic [15:0]     interp;
        logic [LN_W-1:0] ln_c;

        assign xn = (w_x[l] == '0) ? XW'(1) : w_x[l];

        always_comb begin
            msb = '0;
            for (int b = 1; b < XW; b++) begin
                if (xn[b]) begin
                    msb = EW'(b);
                end
            end
        end

        // Mantissa below the leading one, left-aligned to 32 bits.
        assign rest = r_x1[l] & ~(XW'(1) << r_e1[l]);
        assign frac = 32'({rest, 32'd0} >> r_e1[l]);
        assign pos  = PSW'(r_frac[l]) * PSW'(TAB_N);

        assign ta  = w_tab[r_idx[l]];
        assign tb  = w_tab[r_idx[l] + IW'(1)];
        assign tbb = (tb < ta) ? ta : tb;

        assign prod   = 48'(r_dif[l]) * 48'(r_rem4[l]);
        assign interp = r_a[l] + prod[47:32];
        assign ln_c   = LN_W'(r_e4[l]) * LN_W'(LN2_Q16) + LN_W'(interp);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x1[l]   <= xn;
                r_e1[l]   <= msb;
                r_frac[l] <= frac;
                r_e2[l]   <= r_e1[l];
                r_idx[l]  <= pos[PSW-1:32];
                r_rem3[l] <= pos[31:0];
                r_e3[l]   <= r_e2[l];
                r_a[l]    <= ta;
                r_dif[l]  <= tbb - ta;
                r_rem4[l] <= r_rem3[l];
                r_e4[l]   <= r_e3[l];
                r_ln[l]   <= ln_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vv[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vv[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vv[k] <= r_vv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp[0] <= i_payload;
            for (int k = 1; k < LAT; k++) begin
                r_pp[k] <= r_pp[k-1];
            end
            r_diff <= $signed({1'b0, r_ln[0]}) - $signed({1'b0, r_ln[1]});
        end
    end

    assign o_valid   = r_vv[LAT-1];
    assign o_diff    = r_diff;
    assign o_payload = r_pp[LAT-1];

endmodule

// ===== hw/rtl/ntc_adc_to_temperature.sv =====
`timescale 1ns / 1ps

// NTC thermistor temperature from one ADC sample per item, by the beta equation.
// Input channel: i_valid / o_stall with i_adc_sample. Output channel: o_valid /
// i_stall with o_temperature_centi_c, o_resistance_ohms and o_status.
// An item is taken at a clock edge with valid high and stall low.
// Throughput is one item per cycle while the receiver does not stall. Most of
// the pipeline is the three shift-subtract dividers (voltage, resistance and
// temperature, 23 + 24 + 17 stages); the log unit adds 6. The seven parameters
// are written through i_cfg_we / i_cfg_idx / i_cfg_data; unknown indexes are
// ignored. The user must have them written only while no item is in flight;
// the block does not enforce it. Reset (synchronous, active low) empties the
// pipeline and restores the default parameters; the log table is constant and
// needs no fill. When the receiver stalls with a result waiting, the whole
// pipeline holds and o_stall rises in the same cycle: nothing drops or repeats.

module ntc_adc_to_temperature #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [22:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_adc_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_temperature_centi_c,
    output logic [23:0]        o_resistance_ohms,
    output logic [1:0]         o_status
);
    import ntc_pkg::*;

    localparam int P_W = 24 + 1;

    logic en;

    // Parameters
    logic [19:0]        r_series_ohms;
    logic [19:0]        r_r0;
    logic signed [15:0] r_t0;
    logic [14:0]        r_beta;
    logic [22:0]        r_vref;
    logic [22:0]        r_aref;
    logic [14:0]        r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series_ohms <= 20'd10000;
            r_r0     <= 20'd10000;
            r_t0     <= 16'sd2500;
            r_beta   <= 15'd3950;
            r_vref   <= 23'd3300000;
            r_aref   <= 23'd4096000;
            r_fs     <= 15'd32767;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SERIES:     r_series_ohms <= i_cfg_data[19:0];
                CFG_NOMINAL_R:  r_r0     <= i_cfg_data[19:0];
                CFG_NOMINAL_T:  r_t0     <= $signed(i_cfg_data[15:0]);
                CFG_BETA:       r_beta   <= i_cfg_data[14:0];
                CFG_DIV_REF:    r_vref   <= i_cfg_data;
                CFG_ADC_REF:    r_aref   <= i_cfg_data;
                CFG_FULL_SCALE: r_fs     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Stage 0: input register
    logic               r_v0;
    logic signed [15:0] r_smp;

    // Stage 1: sample times ADC reference
    logic        r_v1;
    logic [37:0] r_prod1;
    logic [14:0] r_fs1;
    logic [14:0] smp_pos;
    logic [14:0] fs_nz;

    // Voltage divider
    logic        d1_v;
    logic [22:0] d1_q;
    logic [0:0]  d1_p;
    logic        ovf1;

    // Stage 3: clamp voltage
    logic               r_v3;
    logic signed [23:0] r_vc3;
    logic [23:0]        r_den3;
    logic signed [23:0] vlim;
    logic [22:0]        vm;
    logic signed [23:0] vms;
    logic signed [23:0] vc;

    // Stage 4: numerator
    logic        r_v4;
    logic [42:0] r_num4;
    logic [23:0] r_den4;
    logic        r_np4;

    // Resistance divider
    logic        d2_v;
    logic [23:0] d2_q;
    logic [23:0] d2_r;
    logic [1:0]  d2_p;
    logic        ovf2;

    // Stage 5: resistance and limit test
    logic        r_v5;
    logic [23:0] r_rout5;
    logic        r_disc5;
    logic        disc;
    logic [23:0] rout;
    logic [19:0] r0_nz;

    // Log unit
    logic                      ln_v;
    logic signed [LDIFF_W-1:0] ln_l;
    logic [P_W-1:0]            ln_p;

    // Stage 6
    logic               r_v6;
    logic signed [37:0] r_pl6;
    logic signed [16:0] r_t0c6;
    logic [21:0]        r_b100_6;
    logic [P_W-1:0]     r_p6;
    logic signed [16:0] t0c;
    logic [14:0]        beta_nz;

    // Stage 7
    logic               r_v7;
    logic signed [39:0] r_d7;
    logic [37:0]        r_n7;
    logic signed [16:0] r_t0c7;
    logic [P_W-1:0]     r_p7;
    logic signed [16:0] t0c_abs;

    // Stage 8
    logic           r_v8;
    logic [39:0]    r_ad8;
    logic [37:0]    r_n8;
    logic           r_t0z8;
    logic           r_bad8;
    logic [P_W-1:0] r_p8;

    // Stage 9
    logic           r_v9;
    logic [54:0]    r_nn9;
    logic [39:0]    r_ad9;
    logic           r_t0z9;
    logic           r_bad9;
    logic [P_W-1:0] r_p9;

    // Temperature divider
    logic           d3_v;
    logic [16:0]    d3_q;
    logic [P_W+2:0] d3_p;
    logic           ovf3;

    // Stage 10: output register
    logic               r_v10;
    logic signed [17:0] r_temp;
    logic [23:0]        r_res;
    t_status            r_stat;
    logic [16:0]        tk;
    t_status            stat;

    assign en      = !(r_v10 && i_stall);
    assign o_stall = !en;

    // ---------------- stage 0 / 1 ----------------
    assign smp_pos = r_smp[15] ? 15'd0 : r_smp[14:0];
    assign fs_nz   = (r_fs == '0) ? 15'd1 : r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v0  <= i_valid;
            r_v1  <= r_v0;
            r_v3  <= d1_v;
            r_v4  <= r_v3;
            r_v5  <= d2_v;
            r_v6  <= ln_v;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp   <= i_adc_sample;
            r_prod1 <= 38'(smp_pos) * 38'(r_aref);
            r_fs1   <= fs_nz;
        end
    end

    // A quotient that would not fit 23 bits is above any divider reference.
    assign ovf1 = (r_prod1[37:23] >= r_fs1);

    ntc_div #(.DW(38), .VW(15), .QW(23), .PW(1)) u_div_volt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_v1),
        .i_dividend  (r_prod1),
        .i_divisor   (r_fs1),
        .i_payload   (ovf1),
        .o_valid     (d1_v),
        .o_quotient  (d1_q),
        .o_remainder (),
        .o_payload   (d1_p)
    );

    // ---------------- stage 3 ----------------
    assign vlim = $signed({1'b0, r_vref}) - 24'sd1000;
    assign vm   = (d1_q <= 23'(VOLT_MARGIN)) ? 23'(VOLT_MARGIN) : d1_q;
    assign vms  = $signed({1'b0, vm});
    // The upper clamp wins over the lower one when the reference is small.
    assign vc   = (d1_p[0] || (vms >= vlim)) ? vlim : vms;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vc3  <= vc;
            r_den3 <= 24'($signed({1'b0, r_vref}) - vc);
        end
    end

    // ---------------- stage 4 ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num4 <= 43'(r_series_ohms) * 43'(r_vc3[22:0]);
            r_den4 <= r_den3;
            r_np4  <= (r_vc3 <= 24'sd0);
        end
    end

    assign ovf2 = ({5'd0, r_num4[42:24]} >= r_den4);

    ntc_div #(.DW(43), .VW(24), .QW(24), .PW(2)) u_div_res (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_v4),
        .i_dividend  (r_num4),
        .i_divisor   (r_den4),
        .i_payload   ({ovf2, r_np4}),
        .o_valid     (d2_v),
        .o_quotient  (d2_q),
        .o_remainder (d2_r),
        .o_payload   (d2_p)
    );

    // ---------------- stage 5 ----------------
    // d2_p[0]: voltage not positive, d2_p[1]: quotient overflow.
    always_comb begin
        if (d2_p[0]) begin
            rout = '0;
        end else if (d2_p[1]) begin
            rout = 24'(RES_SAT);
        end else begin
            rout = d2_q;
        end
    end

    assign disc = d2_p[0] || d2_p[1] || (d2_q < 24'(RES_MIN)) || (d2_q > 24'(RES_MAX))
               || ((d2_q == 24'(RES_MAX)) && (d2_r != '0));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rout5 <= rout;
            r_disc5 <= disc;
        end
    end

    assign r0_nz = (r_r0 == '0) ? 20'd1 : r_r0;

    ntc_ln #(.TAB_N(LOG_TABLE_ENTRIES), .PW(P_W)) u_ln (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_v5),
        .i_x0      (r_rout5[RES_W-1:0]),
        .i_x1      (r0_nz),
        .i_payload ({r_rout5, r_disc5}),
        .o_valid   (ln_v),
        .o_diff    (ln_l),
        .o_payload (ln_p)
    );

    // ---------------- stage 6 ----------------
    assign t0c     = 17'(r_t0) + 17'sd27315;
    assign beta_nz = (r_beta == '0) ? 15'd1 : r_beta;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl6    <= 38'(ln_l) * 38'(t0c);
            r_t0c6   <= t0c;
            r_b100_6 <= 22'(beta_nz) * 22'd100;
            r_p6     <= ln_p;
        end
    end

    // ---------------- stage 7 ----------------
    // D = 100 * beta * 2^16 + L * T0, in centikelvin scale.
    assign t0c_abs = r_t0c6[16] ? -r_t0c6 : r_t0c6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d7   <= $signed({2'b00, r_b100_6, 16'd0}) + 40'(r_pl6);
            r_n7   <= 38'(t0c_abs[15:0]) * 38'(r_b100_6);
            r_t0c7 <= r_t0c6;
            r_p7   <= r_p6;
        end
    end

    // ---------------- stage 8 ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ad8  <= r_d7[39] ? 40'(-r_d7) : 40'(r_d7);
            r_n8   <= r_n7;
            r_t0z8 <= (r_t0c7 == 17'sd0);
            r_bad8 <= (r_d7 == 40'sd0) || ((r_d7 > 40'sd0) != (r_t0c7 > 17'sd0));
            r_p8   <= r_p7;
        end
    end

    // ---------------- stage 9 ----------------
    // Add half the divisor so the quotient rounds half up.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nn9  <= {1'b0, r_n8, 16'd0} + 55'(r_ad8 >> 1);
            r_ad9  <= r_ad8;
            r_t0z9 <= r_t0z8;
            r_bad9 <= r_bad8;
            r_p9   <= r_p8;
        end
    end

    assign ovf3 = ({2'b00, r_nn9[54:17]} >= r_ad9);

    ntc_div #(.DW(55), .VW(40), .QW(17), .PW(P_W + 3)) u_div_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_v9),
        .i_dividend  (r_nn9),
        .i_divisor   (r_ad9),
        .i_payload   ({ovf3, r_t0z9, r_bad9, r_p9}),
        .o_valid     (d3_v),
        .o_quotient  (d3_q),
        .o_remainder (),
        .o_payload   (d3_p)
    );

    // ---------------- stage 10 ----------------
    // d3_p: {overflow, T0 at absolute zero, bad sign, resistance, disconnected}
    always_comb begin
        if (d3_p[P_W+1]) begin
            tk = '0;
        end else if (d3_p[P_W+2] || (d3_q > 17'(TK_SAT))) begin
            tk = 17'(TK_SAT);
        end else begin
            tk = d3_q;
        end
    end

    always_comb begin
        priority if (d3_p[0]) begin
            stat = ST_DISC;
        end else if (!d3_p[P_W+1] && d3_p[P_W]) begin
            stat = ST_UNREAL;
        end else begin
            stat = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp <= (stat == ST_OK) ? ($signed({1'b0, tk}) - 18'sd27315) : 18'sd0;
            r_res  <= d3_p[P_W-1:1];
            r_stat <= stat;
        end
    end

    assign o_valid               = r_v10;
    assign o_temperature_centi_c = r_temp;
    assign o_resistance_ohms     = r_res;
    assign o_status              = r_stat;

    a_ok_res_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |->
            (o_resistance_ohms >= 24'(RES_MIN) && o_resistance_ohms <= 24'(RES_MAX)))
        else $error("status ok with resistance outside limits");

    a_fault_temp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_temperature_centi_c == 18'sd0))
        else $error("fault status with nonzero temperature");

    a_temp_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi_c >= -18'sd27315
                     && o_temperature_centi_c <= 18'sd100000))
        else $error("temperature outside saturated range");

endmodule

// ===== bench/ntc_adc_to_temperature_tb.sv =====
`timescale 1ns / 1ps

module ntc_adc_to_temperature_tb;
    import ntc_pkg::*;

    localparam int TAB_N = 256;
    localparam int WATCHDOG_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [22:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_adc_sample;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [17:0] o_temperature_centi_c;
    logic [23:0]        o_resistance_ohms;
    logic [1:0]         o_status;

    ntc_adc_to_temperature #(.LOG_TABLE_ENTRIES(TAB_N)) dut (.*);

    typedef struct packed {
        logic signed [17:0] temp;
        logic [23:0]        res;
        t_status            status;
    } t_reading;

    t_reading reading_q[$];

    // Local copy of the registers.
    longint unsigned series_r, nom_r, beta_k, div_ref, adc_ref, full_code;
    longint          nom_t;
    longint unsigned ln_tab[0:TAB_N];

    int  errors = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  stall_left = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void build_ln_tab();
        longint unsigned z, z2, term, sum, k;
        for (int i = 0; i <= TAB_N; i++) begin
            z = (longint'(i) << 32) / longint'(2 * TAB_N + i);
            z2 = (z * z) >> 32;
            term = z;
            sum = 0;
            k = 1;
            while (term != 0 && k < 200) begin
                sum += term / k;
                term = (term * z2) >> 32;
                k += 2;
            end
            ln_tab[i] = (2 * sum + 32768) >> 16;
        end
    endfunction

    function automatic longint ln_fix(longint unsigned x);
        longint unsigned e, rest, frac, pos, idx, rem, a, b;
        if (x == 0) x = 1;
        e = 0;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        rest = x - (longint'(1) << e);
        frac = (rest << 32) >> e;
        pos = frac * TAB_N;
        idx = pos >> 32;
        rem = pos & 64'hFFFF_FFFF;
        if (idx >= TAB_N) idx = TAB_N - 1;
        a = ln_tab[idx];
        b = ln_tab[idx + 1];
        if (b < a) b = a;
        return longint'(e) * LN2_Q16 + longint'(a + (((b - a) * rem) >> 32));
    endfunction

    function automatic t_reading predict_reading(logic signed [15:0] s);
        longint v, vref, num, den, fs, beta, r0, l, t0c, d, temp_c;
        longint unsigned r_out, tk, n, ad;
        t_reading rd;
        rd.status = ST_OK;
        temp_c = 0;
        fs = (full_code != 0) ? full_code : 1;
        v = (s < 0) ? 0 : (longint'(s) * longint'(adc_ref)) / fs;
        vref = div_ref;
        if (v <= 1000) v = 1000;
        if (v >= vref - 1000) v = vref - 1000;
        den = vref - v;
        num = longint'(series_r) * v;
        if (num < 0) r_out = 0;
        else if (num / den > RES_SAT) r_out = RES_SAT;
        else r_out = num / den;
        if (num < 50 * den || num > 1000000 * den) begin
            rd.status = ST_DISC;
        end else begin
            beta = (beta_k != 0) ? beta_k : 1;
            r0 = (nom_r != 0) ? nom_r : 1;
            l = ln_fix(r_out) - ln_fix(r0);
            t0c = nom_t + 27315;
            d = 100 * beta * 65536 + l * t0c;
            if (t0c == 0) begin
                tk = 0;
            end else if (d == 0 || ((d > 0) != (t0c > 0))) begin
                rd.status = ST_UNREAL;
                tk = 0;
            end else begin
                n = longint'(t0c < 0 ? -t0c : t0c) * 100 * beta * 65536;
                ad = (d < 0) ? -d : d;
                tk = (n + ad / 2) / ad;
            end
            if (rd.status == ST_OK) begin
                if (tk > TK_SAT) tk = TK_SAT;
                temp_c = longint'(tk) - 27315;
            end
        end
        rd.temp = temp_c[17:0];
        rd.res = r_out[23:0];
        return rd;
    endfunction

    task automatic write_reg(t_cfg_idx idx, longint value);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = value[22:0];
        case (idx)
            CFG_SERIES:     series_r = value & 20'hFFFFF;
            CFG_NOMINAL_R:  nom_r = value & 20'hFFFFF;
            CFG_NOMINAL_T:  nom_t = longint'($signed(value[15:0]));
            CFG_BETA:       beta_k = value & 15'h7FFF;
            CFG_DIV_REF:    div_ref = value & 23'h7FFFFF;
            CFG_ADC_REF:    adc_ref = value & 23'h7FFFFF;
            CFG_FULL_SCALE: full_code = value & 15'h7FFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic write_all(longint sr, longint r0, longint t0, longint b,
                             longint dref, longint aref, longint fs);
        write_reg(CFG_SERIES, sr);
        write_reg(CFG_NOMINAL_R, r0);
        write_reg(CFG_NOMINAL_T, t0);
        write_reg(CFG_BETA, b);
        write_reg(CFG_DIV_REF, dref);
        write_reg(CFG_ADC_REF, aref);
        write_reg(CFG_FULL_SCALE, fs);
    endtask

    task automatic send_item(logic signed [15:0] s);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid = 0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid = 1;
        i_adc_sample = s;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Lets the pipeline empty so the registers can be rewritten safely.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 0;
        wait (reading_q.size() == 0);
        repeat (100) @(posedge i_clk);
    endtask

    // Mostly codes that land inside the divider range, some anywhere.
    function automatic logic signed [15:0] pick_sample();
        longint top;
        int sel;
        sel = $urandom_range(0, 9);
        top = (full_code * div_ref) / ((adc_ref != 0) ? adc_ref : 1);
        if (top > 32767) top = 32767;
        if (sel < 6 && top > 0) return 16'($urandom_range(0, 32'(top)));
        return 16'($urandom);
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) send_item(pick_sample());
    endtask

    task automatic test_default_extremes();
        logic signed [15:0] codes[$];
        codes = '{0, 1, -1, 16'sh7FFF, -16'sh8000, 8, 9, 100, 1000, 5000, 8000,
                  10000, 13200, 15000, 20000, 26000, 26390, 26400, 16'sh5555,
                  16'sh2AAA};
        foreach (codes[i]) send_item(codes[i]);
        drain();
    endtask

    task automatic test_special_settings();
        // Zero full scale, zero beta and zero nominal resistance.
        write_all(10000, 0, 2500, 0, 3300000, 100, 0);
        for (int i = 0; i < 20; i++) send_item(16'($urandom_range(0, 40000)));
        drain();
        // Divider reference below the voltage margins.
        write_all(1000000, 1000000, -27300, 20000, 500, 1, 32767);
        for (int i = 0; i < 10; i++) send_item(16'($urandom));
        drain();
        write_reg(CFG_DIV_REF, 2001);
        for (int i = 0; i < 10; i++) send_item(16'($urandom));
        drain();
        // Nominal temperature at absolute zero.
        write_all(10000, 10000, -27315, 3950, 3300000, 4096000, 32767);
        for (int i = 0; i < 15; i++) send_item(16'($urandom_range(0, 26000)));
        drain();
        // Tiny beta with a large nominal resistance drives 1/T negative.
        write_all(1, 1000000, 20000, 1, 6000000, 6144000, 1);
        for (int i = 0; i < 4; i++) send_item(16'(i));
        drain();
        write_reg(CFG_FULL_SCALE, 32767);
        for (int i = 0; i < 20; i++) send_item(16'($urandom_range(0, 32767)));
        drain();
        write_all(1000000, 1, 20000, 20000, 6000000, 1, 1);
        for (int i = 0; i < 10; i++) send_item(16'($urandom));
        drain();
    endtask

    task automatic test_random_settings(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            write_all(longint'($urandom_range(1, 1000000)),
                      longint'($urandom_range(1, 1000000)),
                      longint'($urandom_range(0, 47300)) - 27300,
                      longint'($urandom_range(1, 20000)),
                      longint'($urandom_range(2001, 6000000)),
                      longint'($urandom_range(1, 6144000)),
                      longint'($urandom_range(1, 32767)));
            random_burst(per_phase);
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_all(10000, 10000, 2500, 3950, 3300000, 4096000, 32767);
        hold_req = 1;
        random_burst(200);
        drain();
    endtask

    initial begin
        build_ln_tab();
        series_r = 10000; nom_r = 10000; nom_t = 2500; beta_k = 3950;
        div_ref = 3300000; adc_ref = 4096000; full_code = 32767;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_SERIES;
        i_cfg_data = '0;
        i_valid = 0;
        i_adc_sample = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        test_default_extremes();
        test_special_settings();
        idle_on = 1;
        test_random_settings(8, 150);
        test_backpressure();
        idle_on = 0;
        test_random_settings(1, 200);

        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            i_stall = 1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_stall = 1;
            stall_left = $urandom_range(1, 19) - 1;
        end else begin
            i_stall = 0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            reading_q.push_back(predict_reading(i_adc_sample));
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reading_q.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                want = reading_q.pop_front();
                if (o_temperature_centi_c !== want.temp) begin
                    $error("temperature_centi_c: expected %0d, got %0d",
                           want.temp, o_temperature_centi_c);
                    errors++;
                end
                if (o_resistance_ohms !== want.res) begin
                    $error("resistance_ohms: expected %0d, got %0d",
                           want.res, o_resistance_ohms);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ===== files.f =====
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_div.sv
hw/rtl/ntc_ln.sv
hw/rtl/ntc_adc_to_temperature.sv
bench/ntc_adc_to_temperature_tb.sv
